>>> rtl/pgv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planet gravity vector package
// Widths, configuration register indexes, region codes and the per-item
// side data that travels down the pipeline.
// ----------------------------------------------------------------------------
package pgv_pkg;

    localparam int POS_W  = 32;                  // position and centre width
    localparam int AM_W   = 32;                  // |offset| fits in 32 bits
    localparam int SQR_W  = 2 * AM_W;            // one squared offset
    localparam int SUM_W  = SQR_W + 2;           // sum of three squares
    localparam int RAD_W  = SUM_W + 32;          // radicand S * 2^32
    localparam int ROOT_W = RAD_W / 2;           // distance D, Q.24 km
    localparam int G_W    = 31;                  // radius and gravity width
    localparam int QN_W   = G_W + 48;            // R * 2^48
    localparam int Q_W    = 33;                  // ratio R/d, Q0.32, <= 2^32
    localparam int QCMP_W = ROOT_W + Q_W - 1;
    localparam int F_W    = G_W;                 // final magnitude width
    localparam int FN_W   = G_W + AM_W + 16;     // h2 * |off| * 2^16
    localparam int FCMP_W = ROOT_W + F_W - 1;
    localparam int IDX_W  = 3;
    localparam int OUT_W  = 32;

    localparam logic [IDX_W-1:0] CFG_CENTRE_X = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTRE_Z = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_GRAVITY  = 3'd4;

    localparam logic [1:0] REGION_OUTSIDE = 2'd0;
    localparam logic [1:0] REGION_INSIDE  = 2'd1;
    localparam logic [1:0] REGION_ZERO    = 2'd2;

    typedef struct packed {
        logic [2:0][AM_W-1:0] am;       // offset magnitudes
        logic [2:0]           neg;      // result is negated (offset positive)
        logic                 zero;     // disabled or at the centre
        logic                 interior; // strictly inside the radius
    } t_carry;

endpackage

>>> rtl/planet_gravity_vector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planet gravity vector unit
// Gravity acceleration toward a configured planet centre, inverse square
// outside the surface and linear inside, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The unit accepts one position per clock while the output side does not
// stall and returns its acceleration through 120 register stages: the
// square root (one result bit per stage, 49 stages), the ratio divider
// (33 stages) and the three component dividers that run side by side
// (31 stages); the remaining stages form the offsets, squares, surface test,
// the two scale products, the divider numerators and the output register.
// A stall on the output freezes the whole pipeline; one input request is
// still taken into a skid register, so the input ready is driven from a
// flop. Configuration may only be written while no request is in flight.
module planet_gravity_vector_unit
    import pgv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [95:0]        i_s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [95:0]        o_m_axis_tdata,   // accel_x, accel_y, accel_z
    output logic [1:0]         o_m_axis_tuser    // region
);

    localparam int NST = 3 + ROOT_W + Q_W + 3 + F_W + 1;

    // configuration
    logic signed [POS_W-1:0] r_centre [3];
    logic [G_W-1:0]          r_radius;
    logic [G_W-1:0]          r_grav;
    logic [2*G_W-1:0]        r_r_sq;

    // flow control
    logic             w_en;
    logic             w_in_acc;
    logic             r_skid_v;
    logic [95:0]      r_skid_data;
    logic [95:0]      w_src;
    logic [NST-1:0]   r_vld;

    // front stages
    t_carry           r_p0_c;
    t_carry           r_p1_c;
    t_carry           r_p2_c;
    logic [SQR_W-1:0] r_p1_sq [3];
    logic [SUM_W-1:0] r_p2_s;

    // square root
    t_carry            r_sq_c    [ROOT_W];
    logic [RAD_W-1:0]  r_sq_x    [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    logic [RAD_W-1:0]  n_sq_x    [ROOT_W];
    logic [ROOT_W-1:0] n_sq_root [ROOT_W];

    // ratio divider
    t_carry            r_qd_c   [Q_W];
    logic [ROOT_W-1:0] r_qd_d   [Q_W];
    logic [QN_W-1:0]   r_qd_rem [Q_W];
    logic [Q_W-1:0]    r_qd_q   [Q_W];
    logic [QN_W-1:0]   n_qd_rem [Q_W];
    logic [Q_W-1:0]    n_qd_q   [Q_W];

    // scale products
    t_carry            r_h_c;
    t_carry            r_h2_c;
    t_carry            r_nm_c;
    logic [ROOT_W-1:0] r_h_d;
    logic [ROOT_W-1:0] r_h2_d;
    logic [Q_W-1:0]    r_h_q;
    logic [G_W-1:0]    r_h;
    logic [G_W-1:0]    r_h2;
    logic [63:0]       w_gq;
    logic [63:0]       w_hq;
    logic [FN_W-1:0]   r_nm_num [3];
    logic [ROOT_W-1:0] r_nm_div;

    // component dividers
    t_carry            r_fd_c   [F_W];
    logic [ROOT_W-1:0] r_fd_div [F_W];
    logic [FN_W-1:0]   r_fd_rem [F_W][3];
    logic [F_W-1:0]    r_fd_q   [F_W][3];
    logic [FN_W-1:0]   n_fd_rem [F_W][3];
    logic [F_W-1:0]    n_fd_q   [F_W][3];

    // output register
    logic [95:0]       r_out_data;
    logic [1:0]        r_out_region;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre[0] <= '0;
            r_centre[1] <= '0;
            r_centre[2] <= '0;
            r_radius    <= '0;
            r_grav      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CENTRE_X: r_centre[0] <= i_cfg_wdata;
                CFG_CENTRE_Y: r_centre[1] <= i_cfg_wdata;
                CFG_CENTRE_Z: r_centre[2] <= i_cfg_wdata;
                CFG_RADIUS:   r_radius    <= i_cfg_wdata[G_W-1:0];
                CFG_GRAVITY:  r_grav      <= i_cfg_wdata[G_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r_sq <= (2*G_W)'(r_radius) * (2*G_W)'(r_radius);
    end

    // ------------------------------------------------------------------
    // Flow control: a global enable, a one-entry skid on the input
    // ------------------------------------------------------------------
    assign w_en            = !r_vld[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_v;
    assign w_in_acc        = i_s_axis_tvalid && !r_skid_v;
    assign w_src           = r_skid_v ? r_skid_data : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_vld    <= {r_vld[NST-2:0], r_skid_v || w_in_acc};
            r_skid_v <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_acc) begin
            r_skid_data <= i_s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Offsets, squares, sum and surface test
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin : front
        logic signed [POS_W:0] off;
        t_carry                c;
        if (w_en) begin
            c = '0;
            for (int i = 0; i < 3; i++) begin
                off = {w_src[i*POS_W+POS_W-1], w_src[i*POS_W +: POS_W]}
                    - {r_centre[i][POS_W-1], r_centre[i]};
                c.am[i]  = off[POS_W] ? AM_W'(-off) : AM_W'(off);
                c.neg[i] = !off[POS_W];
            end
            c.zero = (r_radius == '0) || (r_grav == '0)
                  || ((c.am[0] | c.am[1] | c.am[2]) == '0);
            r_p0_c <= c;

            r_p1_c <= r_p0_c;
            for (int i = 0; i < 3; i++) begin
                r_p1_sq[i] <= SQR_W'(r_p0_c.am[i]) * SQR_W'(r_p0_c.am[i]);
            end

            c          = r_p1_c;
            r_p2_s     <= SUM_W'(r_p1_sq[0]) + SUM_W'(r_p1_sq[1]) + SUM_W'(r_p1_sq[2]);
            c.interior = (SUM_W'(r_p1_sq[0]) + SUM_W'(r_p1_sq[1]) + SUM_W'(r_p1_sq[2]))
                       < SUM_W'(r_r_sq);
            r_p2_c     <= c;
        end
    end

    // ------------------------------------------------------------------
    // Square root of S * 2^32, one root bit per stage
    // ------------------------------------------------------------------
    always_comb begin : sq_next
        logic [RAD_W-1:0]  x_in;
        logic [RAD_W-1:0]  trial;
        logic [ROOT_W-1:0] root_in;
        for (int j = 0; j < ROOT_W; j++) begin
            if (j == 0) begin
                x_in    = {r_p2_s, 32'b0};
                root_in = '0;
            end else begin
                x_in    = r_sq_x[j-1];
                root_in = r_sq_root[j-1];
            end
            // (root + 2^b)^2 - root^2, with b the bit decided here
            trial = (RAD_W'(root_in) << (ROOT_W - j))
                  | (RAD_W'(1) << (2 * (ROOT_W - 1 - j)));
            if (x_in >= trial) begin
                n_sq_x[j]    = x_in - trial;
                n_sq_root[j] = root_in | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end else begin
                n_sq_x[j]    = x_in;
                n_sq_root[j] = root_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < ROOT_W; j++) begin
                r_sq_c[j]    <= (j == 0) ? r_p2_c : r_sq_c[(j == 0) ? 0 : j - 1];
                r_sq_x[j]    <= n_sq_x[j];
                r_sq_root[j] <= n_sq_root[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Ratio q = R * 2^48 / D, one quotient bit per stage
    // ------------------------------------------------------------------
    always_comb begin : qd_next
        logic [QN_W-1:0]   rem_in;
        logic [ROOT_W-1:0] d_in;
        logic [Q_W-1:0]    q_in;
        logic [QCMP_W-1:0] shifted;
        for (int j = 0; j < Q_W; j++) begin
            if (j == 0) begin
                rem_in = {r_radius, 48'b0};
                d_in   = r_sq_root[ROOT_W-1];
                q_in   = '0;
            end else begin
                rem_in = r_qd_rem[j-1];
                d_in   = r_qd_d[j-1];
                q_in   = r_qd_q[j-1];
            end
            shifted = QCMP_W'(d_in) << (Q_W - 1 - j);
            if (QCMP_W'(rem_in) >= shifted) begin
                n_qd_rem[j] = QN_W'(QCMP_W'(rem_in) - shifted);
                n_qd_q[j]   = q_in | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
                n_qd_rem[j] = rem_in;
                n_qd_q[j]   = q_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_qd_c[j]   <= (j == 0) ? r_sq_c[ROOT_W-1] : r_qd_c[(j == 0) ? 0 : j - 1];
                r_qd_d[j]   <= (j == 0) ? r_sq_root[ROOT_W-1] : r_qd_d[(j == 0) ? 0 : j - 1];
                r_qd_rem[j] <= n_qd_rem[j];
                r_qd_q[j]   <= n_qd_q[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // h = g * q / 2^32, h2 = h * q / 2^32, then the divider numerators
    // ------------------------------------------------------------------
    assign w_gq = 64'(r_grav) * 64'(r_qd_q[Q_W-1]);
    assign w_hq = 64'(r_h) * 64'(r_h_q);

    always_ff @(posedge i_clk) begin : scale
        logic [G_W-1:0]      mult;
        logic [G_W+AM_W-1:0] prod;
        if (w_en) begin
            r_h_c  <= r_qd_c[Q_W-1];
            r_h_d  <= r_qd_d[Q_W-1];
            r_h_q  <= r_qd_q[Q_W-1];
            r_h    <= w_gq[62:32];

            r_h2_c <= r_h_c;
            r_h2_d <= r_h_d;
            r_h2   <= w_hq[62:32];

            // Inside the planet the divider works on |off| * g / R instead.
            r_nm_c <= r_h2_c;
            mult   = r_h2_c.interior ? r_grav : r_h2;
            for (int i = 0; i < 3; i++) begin
                prod = (G_W+AM_W)'(r_h2_c.am[i]) * (G_W+AM_W)'(mult);
                r_nm_num[i] <= r_h2_c.interior ? FN_W'(prod) : {prod, 16'b0};
            end
            r_nm_div <= r_h2_c.interior ? ROOT_W'(r_radius) : r_h2_d;
        end
    end

    // ------------------------------------------------------------------
    // Component dividers, three side by side, one bit per stage
    // ------------------------------------------------------------------
    always_comb begin : fd_next
        logic [FN_W-1:0]   rem_in;
        logic [ROOT_W-1:0] d_in;
        logic [F_W-1:0]    q_in;
        logic [FCMP_W-1:0] shifted;
        for (int j = 0; j < F_W; j++) begin
            d_in    = (j == 0) ? r_nm_div : r_fd_div[(j == 0) ? 0 : j - 1];
            shifted = FCMP_W'(d_in) << (F_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (j == 0) begin
                    rem_in = r_nm_num[i];
                    q_in   = '0;
                end else begin
                    rem_in = r_fd_rem[j-1][i];
                    q_in   = r_fd_q[j-1][i];
                end
                if (FCMP_W'(rem_in) >= shifted) begin
                    n_fd_rem[j][i] = FN_W'(FCMP_W'(rem_in) - shifted);
                    n_fd_q[j][i]   = q_in | (F_W'(1) << (F_W - 1 - j));
                end else begin
                    n_fd_rem[j][i] = rem_in;
                    n_fd_q[j][i]   = q_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < F_W; j++) begin
                r_fd_c[j]   <= (j == 0) ? r_nm_c : r_fd_c[(j == 0) ? 0 : j - 1];
                r_fd_div[j] <= (j == 0) ? r_nm_div : r_fd_div[(j == 0) ? 0 : j - 1];
                for (int i = 0; i < 3; i++) begin
                    r_fd_rem[j][i] <= n_fd_rem[j][i];
                    r_fd_q[j][i]   <= n_fd_q[j][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: signs, zero case and region
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin : out_stage
        t_carry           c;
        logic [OUT_W-1:0] mag;
        if (w_en) begin
            c = r_fd_c[F_W-1];
            for (int i = 0; i < 3; i++) begin
                mag = OUT_W'(r_fd_q[F_W-1][i]);
                if (c.zero) begin
                    r_out_data[i*OUT_W +: OUT_W] <= '0;
                end else begin
                    r_out_data[i*OUT_W +: OUT_W] <= c.neg[i] ? (~mag + 1'b1) : mag;
                end
            end
            if (c.zero) begin
                r_out_region <= REGION_ZERO;
            end else if (c.interior) begin
                r_out_region <= REGION_INSIDE;
            end else begin
                r_out_region <= REGION_OUTSIDE;
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_region;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_zero_region_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == REGION_ZERO)) |-> (o_m_axis_tdata == '0))
        else $error("zero region result carries nonzero acceleration");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(!w_en))
        else $error("skid register filled while the pipeline was moving");

    a_live_region_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ((o_m_axis_tuser == REGION_OUTSIDE)
                          || (o_m_axis_tuser == REGION_INSIDE)))
        |-> ((r_radius != '0) && (r_grav != '0)))
        else $error("gravity result reported while gravity is disabled");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planet gravity vector unit testbench
// A directed table of positions is sent first, once with the reset settings
// and once with an Earth-like planet. Random positions follow under several
// planet settings, the extremes among them, with phases of input gaps and
// output stalls. Every acceleration is checked against a bit-true predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import pgv_pkg::*;

    typedef struct {
        logic [2:0][31:0] acc;
        logic [1:0]       region;
    } t_accel;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit          typed;   // expectation typed into the row
        t_accel      want;
    } t_row;

    localparam int          HALF = 4;
    localparam logic [31:0] EARTH_R = 32'd6371 << 8;
    localparam logic [31:0] EARTH_G = 32'd980 << 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [95:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    planet_gravity_vector_unit u_top (.*);

    always #HALF i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Planet settings as the unit holds them.
    logic signed [31:0] planet_centre [3];
    logic [30:0]        radius_q;
    logic [30:0]        gravity_q;

    t_accel accel_due [$];
    int     mismatches = 0;
    int     accel_seen = 0;
    int     region_hits [3] = '{0, 0, 0};
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     rx_hold = 0;

    function automatic logic [127:0] isqrt(logic [127:0] s);
        logic [127:0] root;
        logic [127:0] c;
        root = '0;
        for (int b = 55; b >= 0; b--) begin
            c = root | (128'd1 << b);
            if (c * c <= s) root = c;
        end
        return root;
    endfunction

    function automatic t_accel gravity_at(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz);
        t_accel       res;
        longint       off [3];
        logic [127:0] am [3];
        logic [127:0] sq, dist_q, ratio, h, h2, mag;
        off[0] = longint'(signed'(px)) - longint'(planet_centre[0]);
        off[1] = longint'(signed'(py)) - longint'(planet_centre[1]);
        off[2] = longint'(signed'(pz)) - longint'(planet_centre[2]);
        for (int i = 0; i < 3; i++)
            am[i] = (off[i] < 0) ? 128'(-off[i]) : 128'(off[i]);
        res.acc = '0;
        if (radius_q == 0 || gravity_q == 0 || (am[0] | am[1] | am[2]) == 0) begin
            res.region = REGION_ZERO;
            return res;
        end
        sq = am[0] * am[0] + am[1] * am[1] + am[2] * am[2];
        if (sq < 128'(radius_q) * 128'(radius_q)) begin
            res.region = REGION_INSIDE;
            for (int i = 0; i < 3; i++) begin
                mag = am[i] * 128'(gravity_q) / 128'(radius_q);
                res.acc[i] = (off[i] > 0) ? 32'(-mag) : 32'(mag);
            end
        end else begin
            res.region = REGION_OUTSIDE;
            dist_q = isqrt(sq << 32);
            ratio = (128'(radius_q) << 48) / dist_q;
            h = (128'(gravity_q) * ratio) >> 32;
            h2 = (h * ratio) >> 32;
            for (int i = 0; i < 3; i++) begin
                mag = (h2 * (am[i] << 16)) / dist_q;
                res.acc[i] = (off[i] > 0) ? 32'(-mag) : 32'(mag);
            end
        end
        return res;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CENTRE_X: planet_centre[0] = value;
            CFG_CENTRE_Y: planet_centre[1] = value;
            CFG_CENTRE_Z: planet_centre[2] = value;
            CFG_RADIUS:   radius_q = value[30:0];
            CFG_GRAVITY:  gravity_q = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_planet(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad, logic [31:0] grav);
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
        write_reg(CFG_CENTRE_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_GRAVITY, grav);
    endtask

    task automatic wait_drained();
        while (accel_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offers one position and holds it until the unit takes the request.
    task automatic send_pos(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit typed, t_accel want);
        t_accel due;
        if (typed) begin
            due = want;
        end else begin
            due = gravity_at(px, py, pz);
        end
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {pz, py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        accel_due.push_back(due);
        // Lower valid only if no request follows straight away.
        if (idle_pct != 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] near_axis(logic [31:0] ctr, logic [31:0] span);
        longint v;
        v = longint'(signed'(ctr)) +
            longint'($urandom_range(span)) - longint'(span / 2);
        return 32'(v);
    endfunction

    // Picks a position: mostly around the planet, some anywhere.
    task automatic random_pos(output logic [31:0] p [3]);
        int          kind;
        int          axis;
        logic [31:0] span;
        kind = $urandom_range(9);
        span = (radius_q == 0) ? 32'd1000 : 32'(radius_q) * 4;
        if (span > 32'hFFFF_FFF0 || span == 0) span = 32'hFFFF_FFF0;
        for (int i = 0; i < 3; i++) begin
            case (kind)
                0, 1:    p[i] = $urandom;
                2:       p[i] = planet_centre[i] + $urandom_range(3) - 1;
                3:       p[i] = near_axis(planet_centre[i], 32'(radius_q) / 64 + 2);
                default: p[i] = near_axis(planet_centre[i], span);
            endcase
        end
        // Land exactly on the surface along one axis now and then.
        if (kind == 9 && radius_q != 0) begin
            for (int i = 0; i < 3; i++) p[i] = planet_centre[i];
            axis = $urandom_range(2);
            p[axis] = ($urandom_range(1) == 1) ?
                planet_centre[axis] + 32'(radius_q) : planet_centre[axis] - 32'(radius_q);
        end
    endtask

    task automatic run_random(int count);
        logic [31:0] p [3];
        t_accel      none;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            random_pos(p);
            send_pos(p[0], p[1], p[2], 1'b0, none);
        end
        release_input();
    endtask

    // Output side: random stalls, plus a long hold-off when asked for.
    initial begin
        t_accel due;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (accel_due.size() == 0) begin
                    $error("acceleration with no request outstanding");
                    mismatches++;
                end else begin
                    due = accel_due.pop_front();
                    accel_seen++;
                    if (due.region <= REGION_ZERO) region_hits[due.region]++;
                    for (int i = 0; i < 3; i++)
                        if (o_m_axis_tdata[32*i +: 32] !== due.acc[i]) begin
                            $error("accel_%0s: expected %0d, got %0d", i == 0 ? "x" :
                                   i == 1 ? "y" : "z", signed'(due.acc[i]),
                                   signed'(o_m_axis_tdata[32*i +: 32]));
                            mismatches++;
                        end
                    if (o_m_axis_tuser !== due.region) begin
                        $error("region: expected %0d, got %0d", due.region,
                               o_m_axis_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    t_row table_rows [] = '{
        '{32'd0, 32'd0, 32'd0, 1'b1, '{'0, REGION_ZERO}},
        '{EARTH_R, 32'd0, 32'd0, 1'b0, '{'0, REGION_OUTSIDE}},
        '{-EARTH_R, 32'd0, 32'd0, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'd0, EARTH_R, 32'd0, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'd0, 32'd0, -EARTH_R, 1'b0, '{'0, REGION_OUTSIDE}},
        '{EARTH_R - 1, 32'd0, 32'd0, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'd0, 32'd0, 32'd1, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'd1, 32'd1, 32'd1, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'd100, -32'd200, 32'd300, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, '{'0, REGION_OUTSIDE}},
        '{EARTH_R * 3, -EARTH_R, EARTH_R / 2, 1'b0, '{'0, REGION_OUTSIDE}},
        '{EARTH_R / 3, EARTH_R / 3, -EARTH_R / 3, 1'b0, '{'0, REGION_OUTSIDE}},
        '{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{'0, REGION_OUTSIDE}}
    };

    initial begin
        t_accel zero_res;
        zero_res = '{'0, REGION_ZERO};
        planet_centre = '{0, 0, 0};
        radius_q = '0;
        gravity_q = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset settings gravity is off, so every result is zero.
        foreach (table_rows[r])
            send_pos(table_rows[r].px, table_rows[r].py, table_rows[r].pz, 1'b1, zero_res);
        release_input();
        wait_drained();

        set_planet(32'd0, 32'd0, 32'd0, EARTH_R, EARTH_G);
        foreach (table_rows[r])
            send_pos(table_rows[r].px, table_rows[r].py, table_rows[r].pz,
                     table_rows[r].typed, table_rows[r].want);
        release_input();
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_planet(32'd1000, -32'd2000, 32'd3000, EARTH_R, EARTH_G);
                1: set_planet(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF);
                2: set_planet(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1);
                3: set_planet($urandom, $urandom, $urandom, 32'd0, EARTH_G);
                4: set_planet($urandom, $urandom, $urandom, EARTH_R, 32'd0);
                5: set_planet(32'd0, 32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF);
                6: set_planet($urandom, $urandom, $urandom,
                              $urandom_range(32'h7FFF_FFFF), $urandom_range(32'h7FFF_FFFF));
                default: set_planet($urandom, $urandom, $urandom,
                                    $urandom_range(32'h00FF_FFFF, 1), $urandom);
            endcase
            for (int mode = 0; mode < 4; mode++) begin
                idle_pct  = (mode == 1) ? 83 : (mode == 3) ? 33 : 0;
                stall_pct = (mode == 2) ? 83 : (mode == 3) ? 33 : 0;
                run_random(35);
                // Pause the input until everything sent has come back.
                if (mode == 1) wait_drained();
            end
            idle_pct = 0;
            stall_pct = 0;
            // Hold the output off so the pipeline fills and backs up the input.
            if (ph == 0 || ph == 6) begin
                rx_hold = 400;
                run_random(200);
            end
            wait_drained();
        end

        while (accel_due.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("Checked %0d accelerations: %0d outside, %0d inside, %0d zero.",
                 accel_seen, region_hits[REGION_OUTSIDE], region_hits[REGION_INSIDE],
                 region_hits[REGION_ZERO]);
        $display("Planet settings covered reset, Earth-like, extremes and random.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> planet_gravity_vector_unit.f
rtl/pgv_pkg.sv
rtl/planet_gravity_vector_unit.sv
sim/tb_top.sv
